### sv/vvpu_pkg.sv
// Shared types, register indexes, operation codes and helpers for the velocity Verlet update.
// Used by the interfaces' users, the register file, the controller, the datapath and the checker.
// Depends on nothing.
package vvpu_pkg;

   localparam int DATA_W     = 32;
   localparam int ENERGY_W   = 63;
   localparam int NUM_MASS   = 3;
   localparam int CSR_ADDR_W = 5;

   // Register indexes, byte address is four times the index.
   localparam logic [2:0] REG_TIME_STEP      = 3'd0;
   localparam logic [2:0] REG_MASS_KIND0     = 3'd1;
   localparam logic [2:0] REG_MASS_KIND1     = 3'd2;
   localparam logic [2:0] REG_MASS_KIND2     = 3'd3;
   localparam logic [2:0] REG_INV_MASS_KIND0 = 3'd4;
   localparam logic [2:0] REG_INV_MASS_KIND1 = 3'd5;
   localparam logic [2:0] REG_INV_MASS_KIND2 = 3'd6;

   localparam logic [1:0] OP_KICK_DRIFT  = 2'd0;
   localparam logic [1:0] OP_KICK_ENERGY = 2'd1;
   localparam logic [1:0] OP_CLEAR       = 2'd2;

   localparam logic [31:0]         MASS_RESET = 32'h0001_0000;
   localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_F_INV,
      MUL_P_DT,
      MUL_V_DT,
      MUL_V_SQ,
      MUL_M_HI,
      MUL_M_LO
   } mul_sel_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_P,
      WB_V,
      WB_X,
      WB_SQ,
      WB_HI,
      WB_E,
      WB_ACC,
      WB_CLR
   } wb_sel_type;

   typedef struct packed {
      logic        capture;
      logic        out_load;
      logic [1:0]  axis;
      mul_sel_type mul_sel;
      wb_sel_type  wb_sel;
   } cmd_type;

   typedef struct packed {
      logic [31:0]                 time_step;
      logic [NUM_MASS-1:0][31:0]   mass;
      logic [NUM_MASS-1:0][31:0]   inv_mass;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         kind;
      logic               last_of_pass;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0]  new_vel_x;
      logic signed [31:0]  new_vel_y;
      logic signed [31:0]  new_vel_z;
      logic signed [31:0]  new_pos_x;
      logic signed [31:0]  new_pos_y;
      logic signed [31:0]  new_pos_z;
      logic [ENERGY_W-1:0] kind_energy;
      logic                pass_done;
   } rsp_data_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (x < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return x[31:0];
      end
   endfunction

endpackage

### sv/vvpu_stream_if.sv
// Valid/ready channel interfaces for the particle words going in and the result words coming out.
// Field names and widths follow the block's item format; no package dependency.
interface vvpu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [1:0]         kind;
   logic               last_of_pass;
   logic signed [31:0] force_x;
   logic signed [31:0] force_y;
   logic signed [31:0] force_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;

   modport source (
      output valid, op, kind, last_of_pass, force_x, force_y, force_z,
             vel_x, vel_y, vel_z, pos_x, pos_y, pos_z,
      input  ready
   );
   modport sink (
      input  valid, op, kind, last_of_pass, force_x, force_y, force_z,
             vel_x, vel_y, vel_z, pos_x, pos_y, pos_z,
      output ready
   );
endinterface

interface vvpu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic signed [31:0] new_vel_z;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_pos_z;
   logic [62:0]        kind_energy;
   logic               pass_done;

   modport source (
      output valid, new_vel_x, new_vel_y, new_vel_z, new_pos_x, new_pos_y, new_pos_z,
             kind_energy, pass_done,
      input  ready
   );
   modport sink (
      input  valid, new_vel_x, new_vel_y, new_vel_z, new_pos_x, new_pos_y, new_pos_z,
             kind_energy, pass_done,
      output ready
   );
endinterface

### sv/vvpu_csr.sv
// APB-style register file: time step, masses and reciprocal masses of the three kinds.
// Depends on vvpu_pkg.
module vvpu_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [vvpu_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output vvpu_pkg::cfg_type                  cfg
);
   import vvpu_pkg::*;

   cfg_type    cfg_ff;
   logic       write_en;
   logic [2:0] reg_idx;

   assign write_en = psel && penable && pwrite;
   assign reg_idx  = paddr[CSR_ADDR_W-1:2];
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step <= '0;
         cfg_ff.mass      <= {NUM_MASS{MASS_RESET}};
         cfg_ff.inv_mass  <= {NUM_MASS{MASS_RESET}};
      end else if (write_en) begin
         case (reg_idx)
            REG_TIME_STEP:      cfg_ff.time_step   <= pwdata;
            REG_MASS_KIND0:     cfg_ff.mass[0]     <= pwdata;
            REG_MASS_KIND1:     cfg_ff.mass[1]     <= pwdata;
            REG_MASS_KIND2:     cfg_ff.mass[2]     <= pwdata;
            REG_INV_MASS_KIND0: cfg_ff.inv_mass[0] <= pwdata;
            REG_INV_MASS_KIND1: cfg_ff.inv_mass[1] <= pwdata;
            REG_INV_MASS_KIND2: cfg_ff.inv_mass[2] <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TIME_STEP:      prdata = cfg_ff.time_step;
         REG_MASS_KIND0:     prdata = cfg_ff.mass[0];
         REG_MASS_KIND1:     prdata = cfg_ff.mass[1];
         REG_MASS_KIND2:     prdata = cfg_ff.mass[2];
         REG_INV_MASS_KIND0: prdata = cfg_ff.inv_mass[0];
         REG_INV_MASS_KIND1: prdata = cfg_ff.inv_mass[1];
         REG_INV_MASS_KIND2: prdata = cfg_ff.inv_mass[2];
         default:            prdata = '0;
      endcase
   end

endmodule

### sv/vvpu_ctrl.sv
// Sequencer for the velocity Verlet update: walks the three axes through the shared multiplier.
// Issues one command word per cycle to the datapath. Depends on vvpu_pkg.
module vvpu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_op,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vvpu_pkg::cmd_type cmd
);
   import vvpu_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00_0000_0000_0001,
      ST_P_MUL  = 14'b00_0000_0000_0010,
      ST_P_WB   = 14'b00_0000_0000_0100,
      ST_K_MUL  = 14'b00_0000_0000_1000,
      ST_K_WB   = 14'b00_0000_0001_0000,
      ST_D_MUL  = 14'b00_0000_0010_0000,
      ST_D_WB   = 14'b00_0000_0100_0000,
      ST_SQ_MUL = 14'b00_0000_1000_0000,
      ST_HI_MUL = 14'b00_0001_0000_0000,
      ST_LO_MUL = 14'b00_0010_0000_0000,
      ST_E_WB   = 14'b00_0100_0000_0000,
      ST_ACC_WB = 14'b00_1000_0000_0000,
      ST_CLR    = 14'b01_0000_0000_0000,
      ST_DONE   = 14'b10_0000_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      op_in       = op_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.axis    = axis_ff;
      cmd.mul_sel = MUL_NONE;
      cmd.wb_sel  = WB_NONE;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = req_op;
               axis_in     = 2'd0;
               case (req_op)
                  OP_KICK_DRIFT:  state_in = ST_P_MUL;
                  OP_KICK_ENERGY: state_in = ST_P_MUL;
                  OP_CLEAR:       state_in = ST_CLR;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_P_MUL: begin
            cmd.mul_sel = MUL_F_INV;
            state_in    = ST_P_WB;
         end
         ST_P_WB: begin
            cmd.wb_sel = WB_P;
            state_in   = ST_K_MUL;
         end
         ST_K_MUL: begin
            cmd.mul_sel = MUL_P_DT;
            state_in    = ST_K_WB;
         end
         ST_K_WB: begin
            cmd.wb_sel = WB_V;
            state_in   = (op_ff == OP_KICK_DRIFT) ? ST_D_MUL : ST_SQ_MUL;
         end
         ST_D_MUL: begin
            cmd.mul_sel = MUL_V_DT;
            state_in    = ST_D_WB;
         end
         ST_D_WB: begin
            cmd.wb_sel = WB_X;
            if (axis_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_P_MUL;
            end
         end
         ST_SQ_MUL: begin
            cmd.mul_sel = MUL_V_SQ;
            state_in    = ST_HI_MUL;
         end
         // The square still sits in the product register here: its upper half feeds
         // the multiplier while its lower half is saved for the next product.
         ST_HI_MUL: begin
            cmd.mul_sel = MUL_M_HI;
            cmd.wb_sel  = WB_SQ;
            state_in    = ST_LO_MUL;
         end
         ST_LO_MUL: begin
            cmd.mul_sel = MUL_M_LO;
            cmd.wb_sel  = WB_HI;
            state_in    = ST_E_WB;
         end
         ST_E_WB: begin
            cmd.wb_sel = WB_E;
            state_in   = ST_ACC_WB;
         end
         ST_ACC_WB: begin
            cmd.wb_sel = WB_ACC;
            if (axis_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_P_MUL;
            end
         end
         ST_CLR: begin
            cmd.wb_sel = WB_CLR;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 2'd0;
         op_ff        <= OP_KICK_DRIFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/vvpu_dp.sv
// Datapath for the velocity Verlet update: particle registers, one shared 33x33 multiplier,
// rounding and saturation write-back, per-kind energy accumulators and the result register.
// Depends on vvpu_pkg.
module vvpu_dp #(
   parameter int NUM_KINDS = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vvpu_pkg::cmd_type      cmd,
   input  vvpu_pkg::cfg_type      cfg,
   input  vvpu_pkg::req_data_type req_data,
   output vvpu_pkg::rsp_data_type rsp_data
);
   import vvpu_pkg::*;

   localparam int KIND_W = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

   logic [1:0]           kind_ff;
   logic                 last_ff;
   logic signed [31:0]   f_ff [3];
   logic signed [31:0]   v_ff [3];
   logic signed [31:0]   x_ff [3];
   logic signed [31:0]   p_ff;
   logic [31:0]          sq_lo_ff;
   logic [61:0]          hi_ff;
   logic [ENERGY_W-1:0]  e_ff;
   logic signed [64:0]   prod_ff;
   logic [ENERGY_W-1:0]  acc_ff [NUM_KINDS];
   rsp_data_type         rsp_ff;

   logic                 kind_ok;
   logic [KIND_W-1:0]    acc_idx;
   logic [ENERGY_W-1:0]  acc_cur;
   logic signed [31:0]   f_cur, v_cur, x_cur;
   logic [31:0]          mass_cur, inv_cur;
   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   mul_p;
   logic signed [65:0]   prod_x, rnd16, k_wide, v_sum, x_sum;
   logic [64:0]          lo_rnd;
   logic [63:0]          e_sum, acc_sum;
   logic [ENERGY_W-1:0]  e_val, acc_val;

   assign kind_ok  = (int'(req_data.kind) < NUM_KINDS);
   assign f_cur    = f_ff[cmd.axis];
   assign v_cur    = v_ff[cmd.axis];
   assign x_cur    = x_ff[cmd.axis];
   assign mass_cur = cfg.mass[kind_ff];
   assign inv_cur  = cfg.inv_mass[kind_ff];
   assign acc_idx  = kind_ff[KIND_W-1:0];
   assign acc_cur  = acc_ff[acc_idx];
   assign rsp_data = rsp_ff;

   // Operand selection for the shared multiplier; unsigned values are zero-extended.
   always_comb begin
      case (cmd.mul_sel)
         MUL_F_INV: begin
            mul_a = 33'(f_cur);
            mul_b = {1'b0, inv_cur};
         end
         MUL_P_DT: begin
            mul_a = 33'(p_ff);
            mul_b = {1'b0, cfg.time_step};
         end
         MUL_V_DT: begin
            mul_a = 33'(v_cur);
            mul_b = {1'b0, cfg.time_step};
         end
         MUL_V_SQ: begin
            mul_a = 33'(v_cur);
            mul_b = 33'(v_cur);
         end
         MUL_M_HI: begin
            mul_a = {1'b0, mass_cur};
            mul_b = {1'b0, prod_ff[63:32]};
         end
         MUL_M_LO: begin
            mul_a = {1'b0, mass_cur};
            mul_b = {1'b0, sq_lo_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Round half up is an add of half an LSB followed by an arithmetic shift.
   assign prod_x = {prod_ff[64], prod_ff};
   assign rnd16  = (prod_x + 66'sd32768) >>> 16;
   assign k_wide = (prod_x + 66'sd65536) >>> 17;
   assign v_sum  = k_wide + 66'(v_cur);
   assign x_sum  = rnd16 + 66'(x_cur);

   // Energy of one axis: (hi << 16) plus the rounded low product, clamped to 63 bits.
   assign lo_rnd  = {1'b0, prod_ff[63:0]} + 65'd32768;
   assign e_sum   = {1'b0, hi_ff[46:0], 16'd0} + {15'd0, lo_rnd[64:16]};
   assign e_val   = ((|hi_ff[61:47]) || e_sum[63]) ? ENERGY_MAX : e_sum[62:0];
   assign acc_sum = {1'b0, acc_cur} + {1'b0, e_ff};
   assign acc_val = acc_sum[63] ? ENERGY_MAX : acc_sum[62:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_ok ? req_data.kind : 2'd0;
         last_ff <= req_data.last_of_pass;
         f_ff[0] <= req_data.force_x;
         f_ff[1] <= req_data.force_y;
         f_ff[2] <= req_data.force_z;
         v_ff[0] <= req_data.vel_x;
         v_ff[1] <= req_data.vel_y;
         v_ff[2] <= req_data.vel_z;
         x_ff[0] <= req_data.pos_x;
         x_ff[1] <= req_data.pos_y;
         x_ff[2] <= req_data.pos_z;
      end

      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= mul_p[64:0];
      end

      case (cmd.wb_sel)
         WB_P:    p_ff              <= sat32(rnd16);
         WB_V:    v_ff[cmd.axis]    <= sat32(v_sum);
         WB_X:    x_ff[cmd.axis]    <= sat32(x_sum);
         WB_SQ:   sq_lo_ff          <= prod_ff[31:0];
         WB_HI:   hi_ff             <= prod_ff[61:0];
         WB_E:    e_ff              <= e_val;
         default: begin
         end
      endcase

      if (cmd.out_load) begin
         rsp_ff.new_vel_x   <= v_ff[0];
         rsp_ff.new_vel_y   <= v_ff[1];
         rsp_ff.new_vel_z   <= v_ff[2];
         rsp_ff.new_pos_x   <= x_ff[0];
         rsp_ff.new_pos_y   <= x_ff[1];
         rsp_ff.new_pos_z   <= x_ff[2];
         rsp_ff.kind_energy <= acc_cur;
         rsp_ff.pass_done   <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.wb_sel == WB_CLR)) begin
         for (int i = 0; i < NUM_KINDS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (cmd.wb_sel == WB_ACC) begin
         acc_ff[acc_idx] <= acc_val;
      end
   end

endmodule

### sv/velocity_verlet_particle_update.sv
// Top level of the velocity Verlet particle update: register file, sequencer and datapath.
// Depends on vvpu_pkg, vvpu_stream_if, vvpu_csr, vvpu_ctrl and vvpu_dp.
//
//   Port group   Role     Handshake                 Carries
//   req_port     sink     valid/ready               one particle word (op, kind, f, v, x)
//   rsp_port     source   valid/ready               one result word (v', x', energy, done)
//   psel...      slave    APB setup + access        time step, masses, reciprocal masses
//
// One word at a time passes through a single 33x33 multiplier; each product is registered
// before it is written back. Every op (kick and drift, second kick with energy, clear or an
// unused op code) runs to the done step before the next word is accepted.
// The done step loads the result register that drives rsp_port; a new word is taken while
// it waits, and the sequencer holds its last step while the result register is still full.
// Reset is synchronous: accumulators clear to zero, masses and reciprocals to 1.0, dt to 0.
module velocity_verlet_particle_update #(
   parameter int NUM_KINDS = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   vvpu_req_if.sink                        req_port,
   vvpu_rsp_if.source                      rsp_port,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [vvpu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import vvpu_pkg::*;

   cfg_type      cfg;
   cmd_type      cmd;
   req_data_type req_data;
   rsp_data_type rsp_data;
   logic         req_ready;
   logic         rsp_valid;

   assign pready = 1'b1;

   assign req_data.op           = req_port.op;
   assign req_data.kind         = req_port.kind;
   assign req_data.last_of_pass = req_port.last_of_pass;
   assign req_data.force_x      = req_port.force_x;
   assign req_data.force_y      = req_port.force_y;
   assign req_data.force_z      = req_port.force_z;
   assign req_data.vel_x        = req_port.vel_x;
   assign req_data.vel_y        = req_port.vel_y;
   assign req_data.vel_z        = req_port.vel_z;
   assign req_data.pos_x        = req_port.pos_x;
   assign req_data.pos_y        = req_port.pos_y;
   assign req_data.pos_z        = req_port.pos_z;
   assign req_port.ready        = req_ready;

   assign rsp_port.valid       = rsp_valid;
   assign rsp_port.new_vel_x   = rsp_data.new_vel_x;
   assign rsp_port.new_vel_y   = rsp_data.new_vel_y;
   assign rsp_port.new_vel_z   = rsp_data.new_vel_z;
   assign rsp_port.new_pos_x   = rsp_data.new_pos_x;
   assign rsp_port.new_pos_y   = rsp_data.new_pos_y;
   assign rsp_port.new_pos_z   = rsp_data.new_pos_z;
   assign rsp_port.kind_energy = rsp_data.kind_energy;
   assign rsp_port.pass_done   = rsp_data.pass_done;

   vvpu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   vvpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_op    (req_port.op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_port.ready),
      .cmd       (cmd)
   );

   vvpu_dp #(
      .NUM_KINDS (NUM_KINDS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

### sv/vvpu_checker.sv
// Port-level checks for the velocity Verlet update, bound to the top level.
// Depends on vvpu_pkg and on the top level's ports.
module vvpu_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [vvpu_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [31:0]                     pwdata,
   input logic [31:0]                     prdata
);
   import vvpu_pkg::*;

   logic [1:0] pending_ff;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Words taken in but not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
      end
   end

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // At most one word in work and one waiting in the result register.
   a_pending_max : assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 2'd2)
      else $error("too many words in flight");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pending_ff != 2'd0)
      else $error("result word without a request word");

   a_dt_readback : assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[CSR_ADDR_W-1:2] == REG_TIME_STEP) ##1
      (psel && !pwrite && paddr[CSR_ADDR_W-1:2] == REG_TIME_STEP)
      |-> prdata == $past(pwdata))
      else $error("time step readback mismatch");

endmodule

bind velocity_verlet_particle_update vvpu_checker u_vvpu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);
